// File: sv/sbfr_pkg.sv
// ============================================================================
// sbfr_pkg
// Shared constants and types for the S.BUS frame receiver.
// ============================================================================
package sbfr_pkg;

    localparam int unsigned FRAME_LEN = 25;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned CHAN_N    = 16;
    localparam int unsigned CHAN_W    = 11;
    localparam int unsigned ACC_W     = CHAN_W + 7;
    localparam int unsigned CNT_W     = 5;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;

    localparam logic [ADDR_W-1:0] FIRST_DATA_IDX = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST_DATA_IDX  = ADDR_W'(22);
    localparam logic [ADDR_W-1:0] FLAG_IDX       = ADDR_W'(23);
    localparam logic [ADDR_W-1:0] FOOTER_IDX     = ADDR_W'(24);
    localparam logic [ADDR_W-1:0] HEADER_IDX     = ADDR_W'(0);

    localparam logic [3:0] FOOTER_OK_A = 4'h0;
    localparam logic [3:0] FOOTER_OK_B = 4'h4;
    localparam logic [3:0] CHAN_LAST   = 4'(CHAN_N - 1);

    localparam logic [1:0] LINK_OK       = 2'd0;
    localparam logic [1:0] LINK_LOST     = 2'd1;
    localparam logic [1:0] LINK_FAILSAFE = 2'd2;

    // Control of the bit unpacker by the sequencer.
    typedef struct packed {
        logic clear;
        logic load;
        logic take;
    } unp_ctrl_t;

endpackage

// File: sv/sbus_frame_receiver_core.sv
// ============================================================================
// sbus_frame_receiver_core
// Collects S.BUS bytes into 25-byte frames, checks each frame and unpacks its
// sixteen 11-bit channels, or reports a bad frame and resynchronizes.
// ============================================================================
//
//  Channel  | Dir | Payload
//  ---------+-----+-----------------------------------------------------------
//  s_       | in  | tdata: rx_byte
//  m_       | out | tdata: channel fields and counters, tuser: frame_bad,
//           |     | tlast: last result of the frame
//
// A byte that does not complete a frame is taken at once; s_tready is
// high only while the sequencer is idle. A good frame is unpacked through
// one memory read port and one bit accumulator: 22 byte fetches through
// UNPACK, FETCH and MERGE, and one output item per channel. A bad frame
// gives one error item, a scan for the next header (SCAN_RD, SCAN_CHK)
// and, if found, a move of the tail down (COPY_RD, COPY_WR). Output stalls
// hold the sequencer. aresetn is synchronous; buffer contents need no reset.
module sbus_frame_receiver_core
    import sbfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] channel_index, [14:4] channel_value, [15] digital_one,
    // [16] digital_two, [18:17] link_status, [26:19] footer_byte,
    // [58:27] good_count, [90:59] bad_count, [95:91] zero
    output logic [95:0] m_tdata,
    output logic        m_tuser,   // [0] frame_bad
    output logic        m_tlast
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_ERR      = 9'b000000010,
        ST_UNPACK   = 9'b000000100,
        ST_FETCH    = 9'b000001000,
        ST_MERGE    = 9'b000010000,
        ST_SCAN_RD  = 9'b000100000,
        ST_SCAN_CHK = 9'b001000000,
        ST_COPY_RD  = 9'b010000000,
        ST_COPY_WR  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [3:0]        chan_reg, chan_next;
    logic [31:0]       good_reg, good_next;
    logic [31:0]       bad_reg, bad_next;

    logic              m_valid_reg, m_valid_next;
    logic [95:0]       m_data_reg;
    logic              m_user_reg;
    logic              m_last_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        rd_data;
    logic [7:0]        hdr_byte, flag_byte, foot_byte;

    unp_ctrl_t         unp_ctrl;
    logic              have_chan;
    logic [CHAN_W-1:0] chan_value;

    logic              s_accept;
    logic              out_free;
    logic              frame_ok;
    logic              emit_chan, emit_err;
    logic [1:0]        link_status;

    sbfr_frame_mem u_mem (
        .aclk      (aclk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_addr   (rd_ptr_reg),
        .rd_data   (rd_data),
        .hdr_byte  (hdr_byte),
        .flag_byte (flag_byte),
        .foot_byte (foot_byte)
    );

    sbfr_bit_unpacker u_unp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (unp_ctrl),
        .byte_in    (rd_data),
        .have_chan  (have_chan),
        .chan_value (chan_value)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The incoming byte is the footer when it completes the frame.
    assign frame_ok = (hdr_byte == HEADER_BYTE) && (flag_byte[7:4] == 4'h0) &&
                      ((s_tdata[3:0] == FOOTER_OK_A) || (s_tdata[3:0] == FOOTER_OK_B));

    always_comb begin
        priority if (flag_byte[3]) begin
            link_status = LINK_FAILSAFE;
        end else if (flag_byte[2]) begin
            link_status = LINK_LOST;
        end else begin
            link_status = LINK_OK;
        end
    end

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        chan_next   = chan_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        mem_we      = 1'b0;
        mem_waddr   = fill_reg;
        mem_wdata   = s_tdata;
        unp_ctrl    = '0;
        emit_chan   = 1'b0;
        emit_err    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (fill_reg != '0 || s_tdata == HEADER_BYTE)) begin
                    mem_we = 1'b1;
                    if (fill_reg == FOOTER_IDX) begin
                        fill_next = '0;
                        if (frame_ok) begin
                            good_next      = good_reg + 32'd1;
                            unp_ctrl.clear = 1'b1;
                            rd_ptr_next    = FIRST_DATA_IDX;
                            chan_next      = '0;
                            state_next     = ST_UNPACK;
                        end else begin
                            bad_next   = bad_reg + 32'd1;
                            state_next = ST_ERR;
                        end
                    end else begin
                        fill_next = fill_reg + ADDR_W'(1);
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    emit_err    = 1'b1;
                    rd_ptr_next = FIRST_DATA_IDX;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_UNPACK: begin
                if (have_chan) begin
                    if (out_free) begin
                        emit_chan     = 1'b1;
                        unp_ctrl.take = 1'b1;
                        if (chan_reg == CHAN_LAST) begin
                            state_next = ST_IDLE;
                        end else begin
                            chan_next = chan_reg + 4'd1;
                        end
                    end
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                unp_ctrl.load = 1'b1;
                rd_ptr_next   = rd_ptr_reg + ADDR_W'(1);
                state_next    = ST_UNPACK;
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                priority if (rd_data == HEADER_BYTE) begin
                    fill_next  = '0;
                    state_next = ST_COPY_RD;
                end else if (rd_ptr_reg == FOOTER_IDX) begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                // Move the tail down; fill_reg doubles as the write pointer.
                mem_we    = 1'b1;
                mem_wdata = rd_data;
                fill_next = fill_reg + ADDR_W'(1);
                if (rd_ptr_reg == FOOTER_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                    state_next  = ST_COPY_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_chan || emit_err) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            rd_ptr_reg  <= '0;
            chan_reg    <= '0;
            good_reg    <= '0;
            bad_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_ptr_reg  <= rd_ptr_next;
            chan_reg    <= chan_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_chan) begin
            m_data_reg <= {5'd0, bad_reg, good_reg, foot_byte, link_status,
                           flag_byte[1], flag_byte[0], chan_value, chan_reg};
            m_user_reg <= 1'b0;
            m_last_reg <= (chan_reg == CHAN_LAST);
        end else if (emit_err) begin
            m_data_reg <= {5'd0, bad_reg, good_reg, foot_byte, LINK_OK,
                           1'b0, 1'b0, CHAN_W'(0), 4'd0};
            m_user_reg <= 1'b1;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FOOTER_IDX)
        else $error("core: fill level beyond the frame");

    a_fetch_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> (rd_ptr_reg >= FIRST_DATA_IDX &&
                                     rd_ptr_reg <= LAST_DATA_IDX))
        else $error("core: channel fetch outside the data bytes");

    a_last_chan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_chan && chan_reg == CHAN_LAST) |=> (state_reg == ST_IDLE && m_tlast))
        else $error("core: last channel did not end the frame");

    a_err_after_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_err |=> (m_tuser && m_tlast && state_reg == ST_SCAN_RD))
        else $error("core: error item not followed by the header scan");

endmodule

// File: sv/sbfr_frame_mem.sv
// ============================================================================
// sbfr_frame_mem
// 25-byte frame buffer with one write port, one registered read port, and
// taps that keep copies of the header, flag and footer bytes.
// ============================================================================
module sbfr_frame_mem
    import sbfr_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    output logic [7:0]        hdr_byte,
    output logic [7:0]        flag_byte,
    output logic [7:0]        foot_byte
);

    logic [7:0] mem [FRAME_LEN];
    logic [7:0] rd_data_reg;
    logic [7:0] hdr_reg;
    logic [7:0] flag_reg;
    logic [7:0] foot_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // The taps follow every write so the check never needs a read cycle.
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr == HEADER_IDX) begin
            hdr_reg <= wr_data;
        end
        if (wr_en && wr_addr == FLAG_IDX) begin
            flag_reg <= wr_data;
        end
        if (wr_en && wr_addr == FOOTER_IDX) begin
            foot_reg <= wr_data;
        end
    end

    assign rd_data   = rd_data_reg;
    assign hdr_byte  = hdr_reg;
    assign flag_byte = flag_reg;
    assign foot_byte = foot_reg;

endmodule

// File: sv/sbfr_bit_unpacker.sv
// ============================================================================
// sbfr_bit_unpacker
// Bit accumulator that takes frame bytes LSB first and hands out 11-bit
// channel values.
// ============================================================================
module sbfr_bit_unpacker
    import sbfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  unp_ctrl_t         ctrl,
    input  logic [7:0]        byte_in,
    output logic              have_chan,
    output logic [CHAN_W-1:0] chan_value
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        priority if (ctrl.clear) begin
            acc_next = '0;
            cnt_next = '0;
        end else if (ctrl.load) begin
            // Bits above the count are always zero, so an OR merges the byte.
            acc_next = acc_reg | (ACC_W'(byte_in) << cnt_reg);
            cnt_next = cnt_reg + CNT_W'(8);
        end else if (ctrl.take) begin
            acc_next = acc_reg >> CHAN_W;
            cnt_next = cnt_reg - CNT_W'(CHAN_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign have_chan  = (cnt_reg >= CNT_W'(CHAN_W));
    assign chan_value = acc_reg[CHAN_W-1:0];

    a_take_needs_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.take |-> have_chan)
        else $error("unpacker: channel taken with too few bits");

    a_load_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |-> (cnt_reg < CNT_W'(CHAN_W)))
        else $error("unpacker: byte loaded into a full accumulator");

endmodule
